// ----- rtl/rectangle_magnetic_snap_unit_macros.svh -----
// Assertion macros for the rectangle magnetic snap unit.
// Included by every RTL file that carries concurrent assertions.
`ifndef RECTANGLE_MAGNETIC_SNAP_UNIT_MACROS_SVH
`define RECTANGLE_MAGNETIC_SNAP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RMS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define RMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RMS_ASSERT(lbl, clk, rstn, prop, msg)
`define RMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/rms_pkg.sv -----
// Shared widths, edge codes and helpers for the rectangle magnetic snap unit.
// No dependencies.
package rms_pkg;

    localparam int IN_XW   = 16;           // rect_x / rect_y
    localparam int IN_WW   = 15;           // rect_width / rect_height
    localparam int OW      = 25;           // offsets, 8 fractional bits
    localparam int CW      = 18;           // half-pixel coordinates
    localparam int VW      = 19;           // coordinate differences
    localparam int MW      = 25;           // multiplier operand width
    localparam int PW      = 2 * MW;       // multiplier product width
    localparam int NW      = 40;           // determinant / numerators
    localparam int FRAC_W  = 16;           // cut parameter fraction bits
    localparam int TW      = FRAC_W + 2;   // signed cut parameter
    localparam int PXW     = 28;           // hit points, 8 fractional bits
    localparam int LW      = PW + 1;       // squared length

    localparam int OUT_MAX = 16777215;
    localparam int OUT_MIN = -16777216;

    localparam logic signed [PW-1:0] ROUND_HALF = PW'(256);
    localparam int                   PT_SHIFT   = 9;
    localparam int                   C_SHIFT    = 7;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_LEFT   = 2'd1;
    localparam logic [1:0] EDGE_RIGHT  = 2'd2;
    localparam logic [1:0] EDGE_BOTTOM = 2'd3;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPARE = 1'b1;

    function automatic logic signed [OW-1:0] sat_out(input logic signed [PXW:0] v);
        logic signed [OW-1:0] r;
        if (v > (PXW+1)'(OUT_MAX)) begin
            r = OW'(OUT_MAX);
        end else if (v < (PXW+1)'(OUT_MIN)) begin
            r = OW'(OUT_MIN);
        end else begin
            r = OW'(v);
        end
        return r;
    endfunction

endpackage

// ----- rtl/rms_if.sv -----
// Valid/ready channel interfaces for rectangle items and snap results.
// Depends on rms_pkg.
interface rms_item_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    operation;
    logic signed [rms_pkg::IN_XW-1:0]        rect_x;
    logic signed [rms_pkg::IN_XW-1:0]        rect_y;
    logic        [rms_pkg::IN_WW-1:0]        rect_width;
    logic        [rms_pkg::IN_WW-1:0]        rect_height;
    logic                                    last_item;

    modport source (output valid, operation, rect_x, rect_y, rect_width, rect_height,
                    last_item, input ready);
    modport sink   (input valid, operation, rect_x, rect_y, rect_width, rect_height,
                    last_item, output ready);
endinterface

interface rms_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [rms_pkg::OW-1:0]     offset_x;
    logic signed [rms_pkg::OW-1:0]     offset_y;
    logic                              moved;

    modport source (output valid, offset_x, offset_y, moved, input ready);
    modport sink   (input valid, offset_x, offset_y, moved, output ready);
endinterface

// ----- rtl/rectangle_magnetic_snap_unit.sv -----
// Top level of the rectangle magnetic snap unit: sequencer, shared multiplier, state.
// Depends on rms_pkg, rms_if, rms_div and the macro header.
//
//  channel    | dir | handshake   | payload
//  i_item     | in  | valid/ready | operation, rect_x, rect_y, rect_width, rect_height, last_item
//  o_result   | out | valid/ready | offset_x, offset_y, moved
//  i_cfg_*    | in  | write en    | snap_enable
//
// One transaction at a time: a load, or a compare after a touch, skips the edge search; a
// full compare tries each edge on the shared 25x25 multiplier, and on each hit it runs
// the 16-step divider and then the hit point.
// Synchronous active-low reset clears control state.
// A new transaction is taken while a result waits; the sequencer holds at the end of a
// last item only if the previous result is still not taken.
`include "rectangle_magnetic_snap_unit_macros.svh"
module rectangle_magnetic_snap_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,
    rms_item_if.sink     i_item,
    rms_result_if.source o_result
);
    import rms_pkg::*;

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_SETUP  = 20'h00002,
        ST_EDGE   = 20'h00004,
        ST_M0     = 20'h00008,
        ST_M1     = 20'h00010,
        ST_M2     = 20'h00020,
        ST_M3     = 20'h00040,
        ST_NORM   = 20'h00080,
        ST_CHECK  = 20'h00100,
        ST_DIV    = 20'h00200,
        ST_PX     = 20'h00400,
        ST_PXA    = 20'h00800,
        ST_PY     = 20'h01000,
        ST_PYA    = 20'h02000,
        ST_RDONE  = 20'h04000,
        ST_CMP    = 20'h08000,
        ST_LENX   = 20'h10000,
        ST_LENY   = 20'h20000,
        ST_LCMP   = 20'h40000,
        ST_FINISH = 20'h80000
    } t_state;

    t_state r_state, n_state;

    logic                     r_op, r_last;
    logic signed [IN_XW-1:0]  r_rx, r_ry, r_dl, r_dt;
    logic        [IN_WW-1:0]  r_rw, r_rh, r_dw, r_dh;
    logic signed [CW-1:0]     r_c1x, r_c1y, r_eb;
    logic signed [VW-1:0]     r_v0x, r_v0y, r_qx, r_qy;
    logic                     r_rect, r_horiz;
    logic [1:0]               r_edge;
    logic signed [PW-1:0]     r_m0, r_m1;
    logic signed [NW-1:0]     r_det, r_n1, r_n2;
    logic signed [TW-1:0]     r_t, r_t1;
    logic signed [PXW-1:0]    r_px, r_py, r_p1x, r_p1y;
    logic signed [OW-1:0]     r_dx, r_dy, r_bdx, r_bdy;
    logic        [LW-1:0]     r_blen;
    logic                     r_touch, r_snap_en;
    logic                     r_o_valid, r_o_moved;
    logic signed [OW-1:0]     r_ox, r_oy;

    logic signed [CW-1:0]     c1x, c1y, c2x, c2y;
    logic signed [IN_XW-1:0]  sel_l, sel_t;
    logic        [IN_WW-1:0]  sel_w, sel_h;
    logic signed [CW-2:0]     lw, th;
    logic signed [CW-1:0]     x0, y0, x1, y1, w2, h2, s0x, s0y, eb;
    logic signed [MW-1:0]     mul_a, mul_b;
    logic signed [PW-1:0]     prod, rnd_sum, rnd_sh;
    logic signed [NW-1:0]     n2_raw;
    logic                     hit, out_free, o_moved_n;
    logic signed [PXW:0]      gap_x, gap_y;
    logic        [LW-1:0]     new_len;
    logic                     div_done;
    logic [FRAC_W:0]          div_q;

    assign c1x = $signed({r_dl[IN_XW-1], r_dl, 1'b0}) + $signed({3'b000, r_dw});
    assign c1y = $signed({r_dt[IN_XW-1], r_dt, 1'b0}) + $signed({3'b000, r_dh});
    assign c2x = $signed({r_rx[IN_XW-1], r_rx, 1'b0}) + $signed({3'b000, r_rw});
    assign c2y = $signed({r_ry[IN_XW-1], r_ry, 1'b0}) + $signed({3'b000, r_rh});

    assign sel_l = r_rect ? r_dl : r_rx;
    assign sel_t = r_rect ? r_dt : r_ry;
    assign sel_w = r_rect ? r_dw : r_rw;
    assign sel_h = r_rect ? r_dh : r_rh;
    assign lw    = $signed({sel_l[IN_XW-1], sel_l}) + $signed({2'b00, sel_w});
    assign th    = $signed({sel_t[IN_XW-1], sel_t}) + $signed({2'b00, sel_h});
    assign x0    = $signed({sel_l[IN_XW-1], sel_l, 1'b0});
    assign y0    = $signed({sel_t[IN_XW-1], sel_t, 1'b0});
    assign x1    = $signed({lw, 1'b0});
    assign y1    = $signed({th, 1'b0});
    assign w2    = $signed({2'b00, sel_w, 1'b0});
    assign h2    = $signed({2'b00, sel_h, 1'b0});
    assign s0x   = (r_edge == EDGE_TOP || r_edge == EDGE_LEFT) ? x0 : x1;
    assign s0y   = (r_edge == EDGE_TOP || r_edge == EDGE_LEFT) ? y0 : y1;

    always_comb begin
        case (r_edge)
            EDGE_TOP:   eb = w2;
            EDGE_LEFT:  eb = -h2;
            EDGE_RIGHT: eb = h2;
            default:    eb = -w2;
        endcase
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_M0:   begin mul_a = MW'(r_v0y); mul_b = MW'(r_qx); end
            ST_M1:   begin mul_a = MW'(r_v0x); mul_b = MW'(r_qy); end
            ST_M2:   begin mul_a = r_horiz ? MW'(r_v0y) : MW'(r_v0x); mul_b = MW'(r_eb); end
            ST_M3:   begin mul_a = r_horiz ? MW'(r_qy) : MW'(r_qx); mul_b = MW'(r_eb); end
            ST_PX:   begin mul_a = MW'(r_v0x); mul_b = MW'(r_t); end
            ST_PY:   begin mul_a = MW'(r_v0y); mul_b = MW'(r_t); end
            ST_LENX: begin mul_a = r_dx; mul_b = r_dx; end
            ST_LENY: begin mul_a = r_dy; mul_b = r_dy; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign rnd_sum = r_m0 + ROUND_HALF;
    assign rnd_sh  = rnd_sum >>> PT_SHIFT;
    assign n2_raw  = NW'(r_m1 - r_m0);
    assign hit     = (r_det != '0) && !r_n1[NW-1] && (r_n1 <= r_det)
                     && !r_n2[NW-1] && (r_n2 <= r_det);
    assign gap_x   = $signed({r_p1x[PXW-1], r_p1x}) - $signed({r_px[PXW-1], r_px});
    assign gap_y   = $signed({r_p1y[PXW-1], r_p1y}) - $signed({r_py[PXW-1], r_py});
    assign new_len = LW'($unsigned(r_m0)) + LW'($unsigned(r_m1));
    assign out_free  = !r_o_valid || o_result.ready;
    assign o_moved_n = (r_bdx != '0) || (r_bdy != '0);

    rms_div #(
        .DIV_W  (NW),
        .FRAC_W (FRAC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_CHECK && hit),
        .i_num   ($unsigned(r_n1)),
        .i_den   ($unsigned(r_det)),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_item.valid && i_item.ready) n_state = ST_SETUP;
            ST_SETUP:  n_state = (r_op == OP_LOAD || r_touch) ? ST_FINISH : ST_EDGE;
            ST_EDGE:   n_state = ST_M0;
            ST_M0:     n_state = ST_M1;
            ST_M1:     n_state = ST_M2;
            ST_M2:     n_state = ST_M3;
            ST_M3:     n_state = ST_NORM;
            ST_NORM:   n_state = ST_CHECK;
            ST_CHECK: begin
                if (hit) begin
                    n_state = ST_DIV;
                end else if (r_edge == EDGE_BOTTOM) begin
                    n_state = ST_RDONE;
                end else begin
                    n_state = ST_EDGE;
                end
            end
            ST_DIV:    if (div_done) n_state = ST_PX;
            ST_PX:     n_state = ST_PXA;
            ST_PXA:    n_state = ST_PY;
            ST_PY:     n_state = ST_PYA;
            ST_PYA:    n_state = ST_RDONE;
            ST_RDONE:  n_state = r_rect ? ST_CMP : ST_EDGE;
            ST_CMP:    n_state = (r_t1 > r_t) ? ST_LENX : ST_FINISH;
            ST_LENX:   n_state = ST_LENY;
            ST_LENY:   n_state = ST_LCMP;
            ST_LCMP:   n_state = ST_FINISH;
            ST_FINISH: if (!r_last || out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_snap_en <= 1'b1;
            r_touch   <= 1'b0;
            r_o_valid <= 1'b0;
            r_dl      <= '0;
            r_dt      <= '0;
            r_dw      <= '0;
            r_dh      <= '0;
            r_bdx     <= '0;
            r_bdy     <= '0;
            r_blen    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_snap_en <= i_cfg_wr_data;
            end
            if (r_state == ST_FINISH && r_last && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_SETUP: begin
                    if (r_op == OP_LOAD) begin
                        r_dl    <= r_rx;
                        r_dt    <= r_ry;
                        r_dw    <= r_rw;
                        r_dh    <= r_rh;
                        r_bdx   <= '0;
                        r_bdy   <= '0;
                        r_blen  <= '0;
                        r_touch <= 1'b0;
                    end
                end
                ST_CMP: begin
                    if (!(r_t1 > r_t)) begin
                        r_touch <= 1'b1;
                    end
                end
                ST_LCMP: begin
                    if (new_len < r_blen || r_blen == '0) begin
                        r_bdx  <= r_dx;
                        r_bdy  <= r_dy;
                        r_blen <= new_len;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_op   <= i_item.operation;
                r_rx   <= i_item.rect_x;
                r_ry   <= i_item.rect_y;
                r_rw   <= i_item.rect_width;
                r_rh   <= i_item.rect_height;
                r_last <= i_item.last_item;
            end
            ST_SETUP: begin
                r_c1x  <= c1x;
                r_c1y  <= c1y;
                r_v0x  <= VW'(c2x) - VW'(c1x);
                r_v0y  <= VW'(c2y) - VW'(c1y);
                r_rect <= 1'b0;
                r_edge <= EDGE_TOP;
            end
            ST_EDGE: begin
                r_qx    <= VW'(s0x) - VW'(r_c1x);
                r_qy    <= VW'(s0y) - VW'(r_c1y);
                r_eb    <= eb;
                r_horiz <= (r_edge == EDGE_TOP || r_edge == EDGE_BOTTOM);
            end
            ST_M0:   r_m0  <= prod;
            ST_M1:   r_m1  <= prod;
            ST_M2:   r_det <= NW'(prod);
            ST_M3:   r_n1  <= NW'(prod);
            ST_NORM: begin
                if (r_det[NW-1]) begin
                    r_det <= -r_det;
                    r_n1  <= -r_n1;
                    r_n2  <= -n2_raw;
                end else begin
                    r_n2  <= n2_raw;
                end
            end
            ST_CHECK: begin
                if (!hit) begin
                    r_edge <= r_edge + 2'd1;
                    r_t    <= '1;
                    r_px   <= '0;
                    r_py   <= '0;
                end
            end
            ST_DIV:  if (div_done) r_t <= TW'(div_q);
            ST_PX:   r_m0 <= prod;
            ST_PXA:  r_px <= (PXW'(r_c1x) <<< C_SHIFT) + PXW'(rnd_sh);
            ST_PY:   r_m0 <= prod;
            ST_PYA:  r_py <= (PXW'(r_c1y) <<< C_SHIFT) + PXW'(rnd_sh);
            ST_RDONE: begin
                if (!r_rect) begin
                    r_t1   <= r_t;
                    r_p1x  <= r_px;
                    r_p1y  <= r_py;
                    r_rect <= 1'b1;
                    r_edge <= EDGE_TOP;
                end
            end
            ST_CMP: begin
                r_dx <= sat_out(gap_x);
                r_dy <= sat_out(gap_y);
            end
            ST_LENX: r_m0 <= prod;
            ST_LENY: r_m1 <= prod;
            ST_FINISH: begin
                if (r_last && out_free) begin
                    if (r_snap_en && !r_touch) begin
                        r_ox      <= r_bdx;
                        r_oy      <= r_bdy;
                        r_o_moved <= o_moved_n;
                    end else begin
                        r_ox      <= '0;
                        r_oy      <= '0;
                        r_o_moved <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign i_item.ready      = (r_state == ST_IDLE) && i_rst_n;
    assign o_result.valid    = r_o_valid;
    assign o_result.offset_x = r_ox;
    assign o_result.offset_y = r_oy;
    assign o_result.moved    = r_o_moved;

    `RMS_ASSERT(a_moved_match, i_clk, i_rst_n, !o_result.valid || (o_result.moved == ((o_result.offset_x != '0) || (o_result.offset_y != '0))), "moved flag disagrees with offset")
    `RMS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_item.valid && i_item.ready, r_state != ST_IDLE, "sequencer did not start on accepted transaction")
    `RMS_ASSERT(a_len_zero, i_clk, i_rst_n, (r_blen == '0) == ((r_bdx == '0) && (r_bdy == '0)), "kept length and kept vector disagree")
endmodule

// ----- rtl/rms_div.sv -----
// Iterative fraction divider: floor(num * 2^FRAC_W / den) for 0 <= num <= den.
// One quotient bit per cycle. Depends on rms_pkg and the macro header.
`include "rectangle_magnetic_snap_unit_macros.svh"
module rms_div #(
    parameter int DIV_W  = rms_pkg::NW,
    parameter int FRAC_W = rms_pkg::FRAC_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_num,
    input  logic [DIV_W-1:0]  i_den,
    output logic              o_done,
    output logic [FRAC_W:0]   o_quot
);
    import rms_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;
    logic              r_int;
    logic [FRAC_W-1:0] r_frac;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_W:0]    rem2;
    logic              ge;

    assign rem2 = {r_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_int  <= (i_num == i_den);
            r_rem  <= (i_num == i_den) ? '0 : i_num;
            r_frac <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? DIV_W'(rem2 - {1'b0, r_den}) : DIV_W'(rem2);
            r_frac <= {r_frac[FRAC_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = {r_int, r_frac};

    `RMS_ASSERT(a_no_restart, i_clk, i_rst_n, !(i_start && r_busy), "divider restarted while busy")
    `RMS_ASSERT(a_rem_below, i_clk, i_rst_n, !r_busy || (r_rem < r_den), "remainder not below divisor")
    `RMS_ASSERT(a_quot_max, i_clk, i_rst_n, !r_done || !r_int || (r_frac == '0), "quotient above one")
endmodule

// ----- tb/tb.sv -----
// Testbench for rectangle_magnetic_snap_unit: a queue-fed driver, a monitor and
// an inline predictor of the snap offset. Depends on rms_pkg, rms_if and the RTL.
`timescale 1ns / 1ps
module tb;
    import rms_pkg::*;

    typedef struct {
        logic                    op;
        logic signed [IN_XW-1:0] x;
        logic signed [IN_XW-1:0] y;
        logic [IN_WW-1:0]        w;
        logic [IN_WW-1:0]        h;
        logic                    last;
    } rect_t;

    typedef struct {
        logic signed [OW-1:0] dx;
        logic signed [OW-1:0] dy;
        logic                 moved;
    } snap_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_wr_data = 1'b0;

    rms_item_if   item_ch();
    rms_result_if res_ch();

    rectangle_magnetic_snap_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_item       (item_ch.sink),
        .o_result     (res_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    rect_t pending[$];
    snap_t snap_q[$];
    int    errors = 0;
    int    cycles = 0;

    // predictor state
    logic    snap_en = 1'b1;
    longint  d_left = 0, d_top = 0, d_wide = 0, d_tall = 0;
    longint  keep_dx = 0, keep_dy = 0;
    bit      touched = 0;

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint sat(longint v);
        if (v > OUT_MAX) return OUT_MAX;
        if (v < OUT_MIN) return OUT_MIN;
        return v;
    endfunction

    function automatic bit cut(longint c1x, c1y, c2x, c2y, s0x, s0y, s1x, s1y,
                               output longint t, output longint px, output longint py);
        longint v0x, v0y, v1x, v1y, qx, qy, det, n1, n2;
        v0x = c2x - c1x; v0y = c2y - c1y;
        v1x = s1x - s0x; v1y = s1y - s0y;
        qx = s0x - c1x;  qy = s0y - c1y;
        det = v0y * v1x - v0x * v1y;
        n1 = -v1y * qx + v1x * qy;
        n2 = -v0y * qx + v0x * qy;
        t = 0; px = 0; py = 0;
        if (det == 0) return 0;
        if (det < 0) begin
            det = -det; n1 = -n1; n2 = -n2;
        end
        if (n1 < 0 || n1 > det || n2 < 0 || n2 > det) return 0;
        t = (n1 * 65536) / det;
        px = c1x * 128 + fdiv(v0x * t + 256, 512);
        py = c1y * 128 + fdiv(v0y * t + 256, 512);
        return 1;
    endfunction

    // first edge hit in order top, left, right, bottom; -1 when none
    function automatic longint edge_scan(longint c1x, c1y, c2x, c2y, l, tp, w, h,
                                         output longint px, output longint py);
        longint x0, y0, x1, y1, t;
        x0 = 2 * l; y0 = 2 * tp; x1 = 2 * (l + w); y1 = 2 * (tp + h);
        if (cut(c1x, c1y, c2x, c2y, x0, y0, x1, y0, t, px, py)) return t;
        if (cut(c1x, c1y, c2x, c2y, x0, y0, x0, y1, t, px, py)) return t;
        if (cut(c1x, c1y, c2x, c2y, x1, y1, x1, y0, t, px, py)) return t;
        if (cut(c1x, c1y, c2x, c2y, x1, y1, x0, y1, t, px, py)) return t;
        px = 0; py = 0;
        return -1;
    endfunction

    task automatic predict_snap(rect_t r);
        longint c1x, c1y, c2x, c2y, p1x, p1y, p2x, p2y, t1, t2, dx, dy;
        snap_t  s;
        if (r.op == OP_LOAD) begin
            d_left = longint'(r.x); d_top = longint'(r.y);
            d_wide = longint'(r.w); d_tall = longint'(r.h);
            keep_dx = 0; keep_dy = 0; touched = 0;
        end else if (!touched) begin
            c1x = 2 * d_left + d_wide; c1y = 2 * d_top + d_tall;
            c2x = 2 * longint'(r.x) + longint'(r.w);
            c2y = 2 * longint'(r.y) + longint'(r.h);
            t1 = edge_scan(c1x, c1y, c2x, c2y, longint'(r.x), longint'(r.y),
                           longint'(r.w), longint'(r.h), p1x, p1y);
            t2 = edge_scan(c1x, c1y, c2x, c2y, d_left, d_top, d_wide, d_tall, p2x, p2y);
            if (t1 > t2) begin
                dx = sat(p1x - p2x); dy = sat(p1y - p2y);
                if (dx * dx + dy * dy < keep_dx * keep_dx + keep_dy * keep_dy ||
                    keep_dx * keep_dx + keep_dy * keep_dy == 0) begin
                    keep_dx = dx; keep_dy = dy;
                end
            end else begin
                touched = 1;
            end
        end
        if (r.last) begin
            if (!snap_en || touched) begin
                s.dx = '0; s.dy = '0; s.moved = 1'b0;
            end else begin
                s.dx = OW'(keep_dx); s.dy = OW'(keep_dy);
                s.moved = (keep_dx != 0 || keep_dy != 0);
            end
            snap_q.push_back(s);
        end
    endtask

    // driver: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            item_ch.operation <= OP_LOAD;
            item_ch.rect_x <= '0;
            item_ch.rect_y <= '0;
            item_ch.rect_width <= '0;
            item_ch.rect_height <= '0;
            item_ch.last_item <= 1'b0;
        end else if (!item_ch.valid || item_ch.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                item_ch.valid <= 1'b0;
            end else if (pending.size() > 0) begin
                rect_t r;
                r = pending.pop_front();
                item_ch.valid <= 1'b1;
                item_ch.operation <= r.op;
                item_ch.rect_x <= r.x;
                item_ch.rect_y <= r.y;
                item_ch.rect_width <= r.w;
                item_ch.rect_height <= r.h;
                item_ch.last_item <= r.last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: phases of always-ready, random, and long stalls
    int stall_phase = 0, stall_len = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (stall_len == 0) begin
                stall_phase = $urandom_range(0, 2);
                stall_len = $urandom_range(20, 300);
            end
            stall_len--;
            case (stall_phase)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= 1'($urandom_range(0, 1));
                default: res_ch.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // monitor: predict accepted items, check results, track config writes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) snap_en = i_cfg_wr_data;
            if (item_ch.valid && item_ch.ready) begin
                rect_t r;
                r.op = item_ch.operation; r.x = item_ch.rect_x; r.y = item_ch.rect_y;
                r.w = item_ch.rect_width; r.h = item_ch.rect_height;
                r.last = item_ch.last_item;
                predict_snap(r);
            end
            if (res_ch.valid && res_ch.ready) begin
                if (snap_q.size() == 0) begin
                    $error("unexpected result transaction");
                    errors++;
                end else begin
                    snap_t e;
                    e = snap_q.pop_front();
                    if (res_ch.offset_x !== e.dx) begin
                        $error("offset_x exp %0d got %0d", e.dx, res_ch.offset_x);
                        errors++;
                    end
                    if (res_ch.offset_y !== e.dy) begin
                        $error("offset_y exp %0d got %0d", e.dy, res_ch.offset_y);
                        errors++;
                    end
                    if (res_ch.moved !== e.moved) begin
                        $error("moved exp %0d got %0d", e.moved, res_ch.moved);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic rect_t mk(logic op, logic last, int x, int y, int w, int h);
        rect_t r;
        r.op = op; r.last = last;
        r.x = IN_XW'(x); r.y = IN_XW'(y); r.w = IN_WW'(w); r.h = IN_WW'(h);
        return r;
    endfunction

    function automatic rect_t rnd_rect(logic op, logic last);
        rect_t r;
        int k;
        k = $urandom_range(0, 19);
        r.op = op; r.last = last;
        if (k < 2) begin
            r.x = IN_XW'($urandom); r.y = IN_XW'($urandom);
            r.w = IN_WW'($urandom); r.h = IN_WW'($urandom);
        end else begin
            r.x = IN_XW'($urandom_range(0, 800) - 400);
            r.y = IN_XW'($urandom_range(0, 800) - 400);
            r.w = (k == 2) ? '0 : IN_WW'($urandom_range(1, 120));
            r.h = (k == 3) ? '0 : IN_WW'($urandom_range(1, 120));
        end
        return r;
    endfunction

    task automatic wait_idle();
        while (pending.size() > 0 || item_ch.valid || snap_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_enable(logic v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int n, cnt;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_enable(1'b1);
        // directed
        pending.push_back(mk(OP_LOAD, 1'b0, 0, 0, 10, 10));
        pending.push_back(mk(OP_COMPARE, 1'b0, 20, 0, 10, 10));
        pending.push_back(mk(OP_COMPARE, 1'b1, 0, 30, 10, 10));
        pending.push_back(mk(OP_COMPARE, 1'b1, -40, -40, 5, 5));
        pending.push_back(mk(OP_LOAD, 1'b1, 5, 5, 3, 3));
        pending.push_back(mk(OP_LOAD, 1'b0, -32768, -32768, 0, 0));
        pending.push_back(mk(OP_COMPARE, 1'b1, 32767, 32767, 32767, 32767));
        pending.push_back(mk(OP_LOAD, 1'b0, -32768, 0, 1, 1));
        pending.push_back(mk(OP_COMPARE, 1'b1, 32767, 0, 1, 1));
        pending.push_back(mk(OP_LOAD, 1'b0, 0, 0, 20, 20));
        pending.push_back(mk(OP_COMPARE, 1'b0, 5, 5, 4, 4));
        pending.push_back(mk(OP_COMPARE, 1'b1, 100, 0, 10, 10));
        pending.push_back(mk(OP_LOAD, 1'b0, 0, 0, 10, 10));
        pending.push_back(mk(OP_COMPARE, 1'b0, 10, 0, 10, 10));
        pending.push_back(mk(OP_COMPARE, 1'b1, 0, 0, 10, 10));
        pending.push_back(mk(OP_LOAD, 1'b0, 0, 0, 0, 0));
        pending.push_back(mk(OP_COMPARE, 1'b1, 50, 50, 0, 0));
        pending.push_back(mk(OP_LOAD, 1'b0, 0, 0, 10, 10));
        pending.push_back(mk(OP_COMPARE, 1'b0, 30, 30, 10, 10));
        pending.push_back(mk(OP_COMPARE, 1'b1, 15, 0, 10, 10));
        pending.push_back(mk(OP_COMPARE, 1'b1, -32768, 32767, 32767, 0));
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            write_enable((ph == 1 || ph == 5) ? 1'b0 : 1'b1);
            cnt = 0;
            while (cnt < 215) begin
                n = $urandom_range(0, 7);
                if ($urandom_range(0, 9) == 0) begin
                    pending.push_back(rnd_rect(OP_LOAD, 1'($urandom_range(0, 1))));
                    pending.push_back(rnd_rect(OP_COMPARE, 1'b1));
                    cnt += 2;
                end else begin
                    pending.push_back(rnd_rect(OP_LOAD, n == 0));
                    for (int i = 1; i <= n; i++)
                        pending.push_back(rnd_rect(OP_COMPARE,
                            (i == n) || ($urandom_range(0, 9) == 0)));
                    cnt += n + 1;
                end
            end
        end
        wait_idle();
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/rms_pkg.sv
rtl/rms_if.sv
rtl/rms_div.sv
rtl/rectangle_magnetic_snap_unit.sv
tb/tb.sv
